// ----- src/dlts_pkg.sv -----
// ----------------------------------------------------------------------------
// dlts_pkg
// Shared types and codes of the delta-list task scheduler.
// ----------------------------------------------------------------------------
package dlts_pkg;

  // Operation codes of a request.
  localparam logic [1:0] OP_ADD      = 2'd0;
  localparam logic [1:0] OP_DELETE   = 2'd1;
  localparam logic [1:0] OP_TICK     = 2'd2;
  localparam logic [1:0] OP_DISPATCH = 2'd3;

  // Result kinds.
  localparam logic [2:0] KIND_ADDED   = 3'd0;
  localparam logic [2:0] KIND_FULL    = 3'd1;
  localparam logic [2:0] KIND_DELETED = 3'd2;
  localparam logic [2:0] KIND_IGNORED = 3'd3;
  localparam logic [2:0] KIND_DUE     = 3'd4;
  localparam logic [2:0] KIND_RUN     = 3'd5;
  localparam logic [2:0] KIND_NOTHING = 3'd6;

  // At most this many results are reported per request.
  localparam logic [4:0] MAX_RESULTS = 5'd16;

  // Commands from the controller to the datapath.
  typedef enum logic [3:0] {
    DC_IDLE,
    DC_LOAD,
    DC_FREE_NEXT,
    DC_ADD_SET,
    DC_FULL,
    DC_INS_WALK,
    DC_INS_DONE,
    DC_IGNORED,
    DC_DEL_BEGIN,
    DC_SRCH_NEXT,
    DC_REMOVE,
    DC_SLOT_CLR,
    DC_TICK_DEC,
    DC_POP,
    DC_RUN,
    DC_FINISH
  } dlts_cmd_e;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       del_valid;
    logic       scan_end;
    logic       free;
    logic       run_pending;
    logic       scan_oneshot;
    logic       ins_stop;
    logic       srch_end;
    logic       srch_hit;
    logic       head_due;
    logic       cur_periodic;
  } dlts_stat_t;

endpackage

// ----- src/delta_list_task_scheduler.sv -----
// ----------------------------------------------------------------------------
// delta_list_task_scheduler
// Task timer scheduler with a slot table and a delta-ordered ready queue.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the request's last result has been issued. Results appear on
// result_valid_o for one cycle each and cannot be held off, and the final one
// of every request carries last_o. A request steps through each queue
// position walked, each slot scanned and each result: an add walks the
// free-slot scan and then the queue, a delete searches the queue, a tick
// pops due entries and re-inserts periodic ones, and a dispatch scans all
// slots. With the default 16 slots busy stays high the shortest for an
// ignored delete and the longest for a tick in which all 16 periodic slots
// fall due at once and each one walks the whole queue again when it is
// re-inserted. The queue is walked by the single queue walker in the
// datapath, which visits one queue entry per cycle. Up to 16 results are
// reported per request; with more slots the state is still updated in
// full.
// ----------------------------------------------------------------------------
module delta_list_task_scheduler import dlts_pkg::*; #(
  parameter int NUM_SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op_i,
  input  logic [15:0] delay_i,
  input  logic [15:0] period_i,
  input  logic [3:0]  slot_select_i,
  output logic        result_valid_o,
  output logic [2:0]  kind_o,
  output logic [3:0]  slot_out_o,
  output logic        last_o
);

  dlts_cmd_e  cmd;
  dlts_stat_t stat;

  // The controller walks the request through its steps.
  dlts_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // The datapath holds the slots, the queue and the result register.
  dlts_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .op_i           (op_i),
    .delay_i        (delay_i),
    .period_i       (period_i),
    .slot_select_i  (slot_select_i),
    .result_valid_o (result_valid_o),
    .kind_o         (kind_o),
    .slot_out_o     (slot_out_o),
    .last_o         (last_o)
  );

endmodule

// ----- src/dlts_ctrl.sv -----
// ----------------------------------------------------------------------------
// dlts_ctrl
// Sequencer that steps the datapath through one request at a time.
// ----------------------------------------------------------------------------
module dlts_ctrl import dlts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  dlts_stat_t stat_i,
  output dlts_cmd_e  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FREE,
    S_WALK,
    S_SRCH,
    S_CLR,
    S_TCHK,
    S_TPER,
    S_DSP,
    S_FIN
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = DC_IDLE;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o   = DC_LOAD;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat_i.op)
          OP_ADD: state_d = S_FREE;
          OP_DELETE: begin
            if (stat_i.del_valid) begin
              cmd_o   = DC_DEL_BEGIN;
              state_d = S_SRCH;
            end else begin
              cmd_o   = DC_IGNORED;
              state_d = S_FIN;
            end
          end
          OP_TICK: begin
            cmd_o   = DC_TICK_DEC;
            state_d = S_TCHK;
          end
          default: state_d = S_DSP;
        endcase
      end
      S_FREE: begin
        priority if (stat_i.scan_end) begin
          cmd_o   = DC_FULL;
          state_d = S_FIN;
        end else if (stat_i.free) begin
          cmd_o   = DC_ADD_SET;
          state_d = S_WALK;
        end else begin
          cmd_o = DC_FREE_NEXT;
        end
      end
      S_WALK: begin
        if (stat_i.ins_stop) begin
          cmd_o   = DC_INS_DONE;
          state_d = (stat_i.op == OP_TICK) ? S_TCHK : S_FIN;
        end else begin
          cmd_o = DC_INS_WALK;
        end
      end
      S_SRCH: begin
        priority if (stat_i.srch_end) begin
          cmd_o   = DC_SLOT_CLR;
          state_d = (stat_i.op == OP_DISPATCH) ? S_DSP : S_FIN;
        end else if (stat_i.srch_hit) begin
          cmd_o   = DC_REMOVE;
          state_d = S_CLR;
        end else begin
          cmd_o = DC_SRCH_NEXT;
        end
      end
      S_CLR: begin
        cmd_o   = DC_SLOT_CLR;
        state_d = (stat_i.op == OP_DISPATCH) ? S_DSP : S_FIN;
      end
      S_TCHK: begin
        if (stat_i.head_due) begin
          cmd_o   = DC_POP;
          state_d = S_TPER;
        end else begin
          state_d = S_FIN;
        end
      end
      S_TPER: state_d = stat_i.cur_periodic ? S_WALK : S_TCHK;
      S_DSP: begin
        priority if (stat_i.scan_end) begin
          state_d = S_FIN;
        end else if (stat_i.run_pending) begin
          cmd_o   = DC_RUN;
          state_d = stat_i.scan_oneshot ? S_SRCH : S_DSP;
        end else begin
          cmd_o = DC_FREE_NEXT;
        end
      end
      S_FIN: begin
        cmd_o   = DC_FINISH;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

// ----- src/dlts_dp.sv -----
// ----------------------------------------------------------------------------
// dlts_dp
// Slot table, delta-ordered queue and result register of the scheduler.
// ----------------------------------------------------------------------------
module dlts_dp import dlts_pkg::*; #(
  parameter int NUM_SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dlts_cmd_e   cmd_i,
  output dlts_stat_t  stat_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] delay_i,
  input  logic [15:0] period_i,
  input  logic [3:0]  slot_select_i,
  output logic        result_valid_o,
  output logic [2:0]  kind_o,
  output logic [3:0]  slot_out_o,
  output logic        last_o
);

  localparam int IW = $clog2(NUM_SLOTS);
  localparam int PW = $clog2(NUM_SLOTS + 1);

  logic [NUM_SLOTS-1:0] used_q;
  logic [15:0]          dly_q [NUM_SLOTS];
  logic [15:0]          per_q [NUM_SLOTS];
  logic [7:0]           run_q [NUM_SLOTS];
  logic [IW-1:0]        ord_q [NUM_SLOTS];
  logic [PW-1:0]        len_q;

  logic [PW-1:0] ptr_q, scan_q;
  logic [IW-1:0] cur_q;
  logic [15:0]   acc_q, period_q;
  logic [1:0]    op_q;
  logic [3:0]    sel_q;

  logic          pend_v_q;
  logic [2:0]    pend_kind_q;
  logic [3:0]    pend_slot_q;
  logic [4:0]    res_cnt_q;

  logic [IW-1:0] ptr_idx, scan_idx, sel_idx, q_idx, nxt_idx, head_idx;
  logic [PW-1:0] nxt_pos;
  logic          ptr_lt_len;
  logic          emit;
  logic          emit_ok;
  logic [2:0]    emit_kind;
  logic [3:0]    emit_slot;

  assign ptr_idx  = ptr_q[IW-1:0];
  assign scan_idx = scan_q[IW-1:0];
  assign sel_idx  = IW'(sel_q);
  assign q_idx    = ord_q[ptr_idx];
  assign nxt_pos  = ptr_q + 1'b1;
  assign nxt_idx  = ord_q[nxt_pos[IW-1:0]];
  assign head_idx = ord_q[0];
  assign ptr_lt_len = (ptr_q < len_q);
  assign emit_ok  = emit && (res_cnt_q < MAX_RESULTS);

  always_comb begin
    stat_o.op           = op_q;
    stat_o.del_valid    = (int'(sel_q) < NUM_SLOTS) && used_q[sel_idx];
    stat_o.scan_end     = (scan_q == PW'(NUM_SLOTS));
    stat_o.free         = !used_q[scan_idx];
    stat_o.run_pending  = (run_q[scan_idx] != 8'd0);
    stat_o.scan_oneshot = (per_q[scan_idx] == 16'd0);
    stat_o.ins_stop     = !ptr_lt_len || (acc_q < dly_q[q_idx]);
    stat_o.srch_end     = !ptr_lt_len;
    stat_o.srch_hit     = ptr_lt_len && (q_idx == cur_q);
    stat_o.head_due     = (len_q != '0) && (dly_q[head_idx] == 16'd0);
    stat_o.cur_periodic = (per_q[cur_q] != 16'd0);
  end

  always_comb begin
    emit      = 1'b0;
    emit_kind = KIND_NOTHING;
    emit_slot = 4'd0;
    unique case (cmd_i)
      DC_ADD_SET: begin
        emit = 1'b1; emit_kind = KIND_ADDED; emit_slot = 4'(scan_idx);
      end
      DC_FULL: begin
        emit = 1'b1; emit_kind = KIND_FULL;
      end
      DC_IGNORED: begin
        emit = 1'b1; emit_kind = KIND_IGNORED; emit_slot = sel_q;
      end
      DC_DEL_BEGIN: begin
        emit = 1'b1; emit_kind = KIND_DELETED; emit_slot = sel_q;
      end
      DC_POP: begin
        emit = 1'b1; emit_kind = KIND_DUE; emit_slot = 4'(head_idx);
      end
      DC_RUN: begin
        emit = 1'b1; emit_kind = KIND_RUN; emit_slot = 4'(scan_idx);
      end
      default: ;
    endcase
  end

  // Scheduler state that reset clears.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q         <= '0;
      len_q          <= '0;
      pend_v_q       <= 1'b0;
      pend_kind_q    <= KIND_NOTHING;
      pend_slot_q    <= '0;
      res_cnt_q      <= '0;
      result_valid_o <= 1'b0;
      last_o         <= 1'b0;
      kind_o         <= KIND_NOTHING;
      slot_out_o     <= '0;
      for (int j = 0; j < NUM_SLOTS; j++) begin
        dly_q[j] <= '0;
        per_q[j] <= '0;
        run_q[j] <= '0;
      end
    end else begin
      result_valid_o <= (emit_ok && pend_v_q) || (cmd_i == DC_FINISH);
      last_o         <= (cmd_i == DC_FINISH);
      if (emit_ok) begin
        res_cnt_q   <= res_cnt_q + 1'b1;
        pend_v_q    <= 1'b1;
        pend_kind_q <= emit_kind;
        pend_slot_q <= emit_slot;
        if (pend_v_q) begin
          kind_o     <= pend_kind_q;
          slot_out_o <= pend_slot_q;
        end
      end
      unique case (cmd_i)
        DC_LOAD: begin
          res_cnt_q <= '0;
          pend_v_q  <= 1'b0;
        end
        DC_ADD_SET: begin
          used_q[scan_idx] <= 1'b1;
          per_q[scan_idx]  <= period_q;
          run_q[scan_idx]  <= '0;
        end
        DC_INS_DONE: begin
          if (ptr_lt_len) dly_q[q_idx] <= dly_q[q_idx] - acc_q;
          dly_q[cur_q] <= acc_q;
          len_q        <= len_q + 1'b1;
        end
        DC_REMOVE: begin
          if (nxt_pos < len_q) dly_q[nxt_idx] <= dly_q[nxt_idx] + dly_q[q_idx];
          len_q <= len_q - 1'b1;
        end
        DC_SLOT_CLR: begin
          used_q[cur_q] <= 1'b0;
          dly_q[cur_q]  <= '0;
          per_q[cur_q]  <= '0;
          run_q[cur_q]  <= '0;
        end
        DC_TICK_DEC: begin
          if (len_q != '0 && dly_q[head_idx] != 16'd0) begin
            dly_q[head_idx] <= dly_q[head_idx] - 1'b1;
          end
        end
        DC_POP: begin
          if (run_q[head_idx] != 8'hFF) run_q[head_idx] <= run_q[head_idx] + 1'b1;
          len_q <= len_q - 1'b1;
        end
        DC_RUN: run_q[scan_idx] <= run_q[scan_idx] - 1'b1;
        DC_FINISH: begin
          pend_v_q   <= 1'b0;
          kind_o     <= pend_v_q ? pend_kind_q : KIND_NOTHING;
          slot_out_o <= pend_v_q ? pend_slot_q : 4'd0;
        end
        default: ;
      endcase
    end
  end

  // Queue order and working registers.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      DC_LOAD: begin
        op_q     <= op_i;
        acc_q    <= delay_i;
        period_q <= period_i;
        sel_q    <= slot_select_i;
        scan_q   <= '0;
        ptr_q    <= '0;
      end
      DC_FREE_NEXT: scan_q <= scan_q + 1'b1;
      DC_ADD_SET: begin
        cur_q <= scan_idx;
        ptr_q <= '0;
      end
      DC_INS_WALK: begin
        acc_q <= acc_q - dly_q[q_idx];
        ptr_q <= ptr_q + 1'b1;
      end
      DC_INS_DONE: begin
        for (int j = 1; j < NUM_SLOTS; j++) begin
          if (PW'(j) > ptr_q && PW'(j) <= len_q) ord_q[j] <= ord_q[j-1];
        end
        ord_q[ptr_idx] <= cur_q;
      end
      DC_DEL_BEGIN: begin
        cur_q <= sel_idx;
        ptr_q <= '0;
      end
      DC_SRCH_NEXT: ptr_q <= ptr_q + 1'b1;
      DC_REMOVE: begin
        for (int j = 0; j < NUM_SLOTS - 1; j++) begin
          if (PW'(j) >= ptr_q && PW'(j + 1) < len_q) ord_q[j] <= ord_q[j+1];
        end
      end
      DC_SLOT_CLR: scan_q <= scan_q + 1'b1;
      DC_POP: begin
        for (int j = 0; j < NUM_SLOTS - 1; j++) begin
          if (PW'(j + 1) < len_q) ord_q[j] <= ord_q[j+1];
        end
        cur_q <= head_idx;
        acc_q <= per_q[head_idx];
        ptr_q <= '0;
      end
      DC_RUN: begin
        cur_q <= scan_idx;
        ptr_q <= '0;
        if (per_q[scan_idx] != 16'd0) scan_q <= scan_q + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ----- src/dlts_checker.sv -----
// ----------------------------------------------------------------------------
// dlts_checker
// Port-level checks of the scheduler's request and result sequencing.
// ----------------------------------------------------------------------------
module dlts_checker import dlts_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       result_valid_o,
  input logic [2:0] kind_o,
  input logic       last_o
);

  // A taken request makes the block busy.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("request not taken");

  // A result that is not the last one arrives while the request is in work.
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy) else $error("result after finish");

  // The block goes idle exactly with the last result.
  a_fell_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o && last_o) else $error("idle without last");

  // Nothing follows a last result directly.
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |=> !result_valid_o) else $error("extra result");

  // Result kinds stay within the defined codes.
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> kind_o <= KIND_NOTHING) else $error("bad kind");

endmodule

bind delta_list_task_scheduler dlts_checker u_dlts_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .kind_o         (kind_o),
  .last_o         (last_o)
);
